// ===== rtl/core/least_service_thread_ranker_core_defines.svh =====
// Assertion helpers used by the ranker sequencer (lstr_seq).
`ifndef LEAST_SERVICE_THREAD_RANKER_CORE_DEFINES_SVH
`define LEAST_SERVICE_THREAD_RANKER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LSTR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ranker check failed");

// Next-cycle implication, checked outside reset.
`define LSTR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ranker check failed");

`endif

// ===== rtl/core/lstr_pkg.sv =====
`timescale 1ns / 1ps
package lstr_pkg;

  localparam int NUM_THREADS_DEF     = 16;
  localparam int MAX_CONTROLLERS_DEF = 16;

  localparam int SVC_W   = 32;
  localparam int TOTAL_W = 48;
  localparam int DECAY_W = 16;
  localparam int CC_W    = 5;
  localparam int RANK_W  = 4;
  localparam int TID_W   = 4;
  localparam int ACT_W   = 2;

  localparam logic [CC_W-1:0]    CC_RESET    = 5'd1;
  localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd57344;

  typedef enum logic [ACT_W-1:0] {
    ACT_REPORT = 2'd0,
    ACT_DONE   = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic {
    REG_CTRL_COUNT = 1'b0,
    REG_DECAY      = 1'b1
  } reg_idx_t;

  // Phase strobes broadcast from the sequencer to every cell.
  typedef struct packed {
    logic               mul;
    logic               add;
    logic               load;
    logic               sweep;
    logic [DECAY_W-1:0] alpha;
  } lstr_ctl_t;

endpackage

// ===== rtl/core/lstr_cell.sv =====
`timescale 1ns / 1ps
module lstr_cell #(
  parameter int NUM_THREADS = lstr_pkg::NUM_THREADS_DEF,
  parameter int CELL_ID     = 0,
  parameter int IDW         = $clog2(NUM_THREADS)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lstr_pkg::lstr_ctl_t         ctl_i,
  input  logic                        rpt_en_i,
  input  logic [lstr_pkg::SVC_W-1:0]  rpt_amount_i,
  input  logic [lstr_pkg::TOTAL_W-1:0] probe_total_i,
  input  logic [IDW-1:0]              probe_id_i,
  input  logic                        probe_valid_i,
  output logic [lstr_pkg::TOTAL_W-1:0] probe_total_o,
  output logic [IDW-1:0]              probe_id_o,
  output logic                        probe_valid_o,
  output logic [lstr_pkg::RANK_W-1:0] rank_o,
  output logic                        ever_o
);
  import lstr_pkg::*;

  localparam logic [IDW-1:0] MY_ID = IDW'(CELL_ID);

  logic [SVC_W-1:0]   q_r;
  logic               rep_r;
  logic [TOTAL_W-1:0] tot_r;
  logic               ever_r;
  logic [RANK_W-1:0]  rank_r;
  logic [63:0]        pa_r;
  logic [48:0]        pb_r;
  logic [TOTAL_W-1:0] pt_r;
  logic [IDW-1:0]     pid_r;
  logic               pv_r;

  logic [SVC_W:0]     sum;
  logic [DECAY_W:0]   beta;
  logic [63:0]        pa_nxt;
  logic [48:0]        pb_nxt;
  logic [TOTAL_W-1:0] tot_nxt;
  logic               beats;

  always_comb begin
    sum     = {1'b0, q_r} + {1'b0, rpt_amount_i};
    beta    = 17'h10000 - {1'b0, ctl_i.alpha};
    pa_nxt  = {48'd0, ctl_i.alpha} * {16'd0, tot_r};
    pb_nxt  = {32'd0, beta} * {17'd0, q_r};
    tot_nxt = pa_r[63:16] + pb_r[TOTAL_W-1:0];
    // The passing entry ranks ahead of this thread when it is smaller, or equal
    // with a lower thread id.
    beats   = probe_valid_i &&
              ((probe_total_i < tot_r) || ((probe_total_i == tot_r) && (probe_id_i < MY_ID)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r    <= '0;
      rep_r  <= 1'b0;
      tot_r  <= '0;
      ever_r <= 1'b0;
      rank_r <= '0;
      pv_r   <= 1'b0;
    end else begin
      if (rpt_en_i) begin
        q_r   <= sum[SVC_W] ? '1 : sum[SVC_W-1:0];
        rep_r <= 1'b1;
      end
      if (ctl_i.add) begin
        if (rep_r) begin
          tot_r  <= tot_nxt;
          ever_r <= 1'b1;
        end
        q_r   <= '0;
        rep_r <= 1'b0;
      end
      if (ctl_i.load) begin
        rank_r <= '0;
        pv_r   <= ever_r;
      end
      if (ctl_i.sweep) begin
        pv_r <= probe_valid_i;
        if (ever_r && beats) begin
          rank_r <= rank_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.mul) begin
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
    end
    if (ctl_i.load) begin
      pt_r  <= tot_r;
      pid_r <= MY_ID;
    end else if (ctl_i.sweep) begin
      pt_r  <= probe_total_i;
      pid_r <= probe_id_i;
    end
  end

  assign probe_total_o = pt_r;
  assign probe_id_o    = pid_r;
  assign probe_valid_o = pv_r;
  assign rank_o        = rank_r;
  assign ever_o        = ever_r;

endmodule

// ===== rtl/core/lstr_seq.sv =====
`timescale 1ns / 1ps
`include "least_service_thread_ranker_core_defines.svh"
module lstr_seq #(
  parameter int NUM_THREADS     = lstr_pkg::NUM_THREADS_DEF,
  parameter int MAX_CONTROLLERS = lstr_pkg::MAX_CONTROLLERS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         done_i,
  input  logic [lstr_pkg::CC_W-1:0]    ctrl_count_i,
  input  logic [lstr_pkg::DECAY_W-1:0] alpha_i,
  output lstr_pkg::lstr_ctl_t          ctl_o,
  output logic                         idle_o
);
  import lstr_pkg::*;

  localparam int SCW = (NUM_THREADS > 2) ? $clog2(NUM_THREADS) : 1;
  localparam int FCW = $clog2(MAX_CONTROLLERS + 1);
  localparam logic [SCW-1:0] SWEEP_LAST = SCW'(NUM_THREADS - 2);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_ADD   = 5'b00100,
    S_LOAD  = 5'b01000,
    S_SWEEP = 5'b10000
  } state_t;

  state_t         state_r, state_nxt;
  logic [SCW-1:0] cnt_r, cnt_nxt;
  logic [FCW-1:0] fin_r, fin_nxt;
  logic [6:0]     need;
  logic [6:0]     fin_inc;
  logic           start;

  always_comb begin
    if (ctrl_count_i == '0) begin
      need = 7'd1;
    end else if (7'(ctrl_count_i) > 7'(MAX_CONTROLLERS)) begin
      need = 7'(MAX_CONTROLLERS);
    end else begin
      need = 7'(ctrl_count_i);
    end
    fin_inc = 7'(fin_r) + 7'd1;
    start   = done_i && (fin_inc >= need);
    fin_nxt = fin_r;
    if (done_i) begin
      fin_nxt = start ? '0 : FCW'(fin_inc);
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ADD;
      S_ADD:   state_nxt = S_LOAD;
      S_LOAD: begin
        state_nxt = S_SWEEP;
        cnt_nxt   = '0;
      end
      S_SWEEP: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == SWEEP_LAST) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      fin_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      fin_r   <= fin_nxt;
    end
  end

  always_comb begin
    ctl_o.mul   = (state_r == S_MUL);
    ctl_o.add   = (state_r == S_ADD);
    ctl_o.load  = (state_r == S_LOAD);
    ctl_o.sweep = (state_r == S_SWEEP);
    ctl_o.alpha = alpha_i;
  end

  assign idle_o = (state_r == S_IDLE);

  `LSTR_ASSERT_IMP(a_done_only_idle, clk, rst_n, done_i, state_r == S_IDLE)
  `LSTR_ASSERT_NXT(a_start_to_mul, clk, rst_n, start, state_r == S_MUL)
  `LSTR_ASSERT_NXT(a_mul_to_add, clk, rst_n, state_r == S_MUL, state_r == S_ADD)
  `LSTR_ASSERT_NXT(a_load_clears_cnt, clk, rst_n, state_r == S_LOAD, cnt_r == '0)
  `LSTR_ASSERT_NXT(a_sweep_ends, clk, rst_n,
                   (state_r == S_SWEEP) && (cnt_r == SWEEP_LAST), state_r == S_IDLE)

endmodule

// ===== rtl/core/least_service_thread_ranker_core.sv =====
`timescale 1ns / 1ps
// Least-attained-service thread ranker.
// Input stream (in_*): in_tuser carries the action (report, controller done,
// query); in_tdata carries the thread id and the service amount. A report adds
// to the thread's per-quantum sum; a done word counts finished controllers.
// When the configured controller count is reached, the block re-ranks: it forms
// the products, then the new totals, then loads the ring, then sweeps it until
// every cell's total has passed each other cell. A re-rank holds in_tready low
// after the triggering done word until the sweep ends. A query returns one
// word on out_* from a register, in the cycle after it is accepted. Reports and
// queries otherwise need no wait between them.
// If the receiver stalls with a result waiting, in_tready drops until the
// result is taken; nothing is dropped.
// Reset (synchronous, rst_n low) clears all sums, totals and ranks and loads
// controller_count = 1 and decay_weight = 57344. The APB port (cfg_*) holds
// controller_count at byte 0 and decay_weight at byte 4; write it while idle.
module least_service_thread_ranker_core #(
  parameter int NUM_THREADS     = lstr_pkg::NUM_THREADS_DEF,
  parameter int MAX_CONTROLLERS = lstr_pkg::MAX_CONTROLLERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [3:0] thread_id, [35:4] service_amount, [39:36] zero
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [3:0] thread_rank, [4] unranked, [7:5] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lstr_pkg::*;

  localparam int IDW = $clog2(NUM_THREADS);

  logic [CC_W-1:0]    cc_r;
  logic [DECAY_W-1:0] decay_r;
  logic               out_valid_r;
  logic [RANK_W-1:0]  out_rank_r;
  logic               out_unr_r;

  lstr_ctl_t          ctl;
  logic               idle;
  logic               in_acc;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;
  action_t            act;
  logic [TID_W-1:0]   tid;
  logic [SVC_W-1:0]   amount;
  logic               sel_ever;
  logic [RANK_W-1:0]  sel_rank;

  logic [NUM_THREADS-1:0] rpt_en;
  logic [NUM_THREADS-1:0] ever;
  logic [RANK_W-1:0]      rank   [NUM_THREADS];
  logic [TOTAL_W-1:0]     pr_tot [NUM_THREADS];
  logic [IDW-1:0]         pr_id  [NUM_THREADS];
  logic [NUM_THREADS-1:0] pr_val;

  assign act    = action_t'(in_tuser);
  assign tid    = in_tdata[3:0];
  assign amount = in_tdata[35:4];

  assign in_tready = idle && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (cfg_idx)
      REG_CTRL_COUNT: cfg_prdata = {27'd0, cc_r};
      REG_DECAY:      cfg_prdata = {16'd0, decay_r};
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r    <= CC_RESET;
      decay_r <= DECAY_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CTRL_COUNT: cc_r    <= cfg_pwdata[CC_W-1:0];
        REG_DECAY:      decay_r <= cfg_pwdata[DECAY_W-1:0];
        default:        ;
      endcase
    end
  end

  // Query lookup; ids at or above NUM_THREADS match no cell and read as unranked.
  always_comb begin
    sel_ever = 1'b0;
    sel_rank = '0;
    for (int i = 0; i < NUM_THREADS; i++) begin
      if (int'(tid) == i) begin
        sel_ever = ever[i];
        sel_rank = rank[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && (act == ACT_QUERY)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (act == ACT_QUERY)) begin
      out_rank_r <= sel_ever ? sel_rank : '0;
      out_unr_r  <= !sel_ever;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_unr_r, out_rank_r};

  lstr_seq #(
    .NUM_THREADS     (NUM_THREADS),
    .MAX_CONTROLLERS (MAX_CONTROLLERS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .done_i       (in_acc && (act == ACT_DONE)),
    .ctrl_count_i (cc_r),
    .alpha_i      (decay_r),
    .ctl_o        (ctl),
    .idle_o       (idle)
  );

  for (genvar g = 0; g < NUM_THREADS; g++) begin : g_cell
    localparam int PREV = (g == 0) ? NUM_THREADS - 1 : g - 1;

    assign rpt_en[g] = in_acc && (act == ACT_REPORT) && (int'(tid) == g);

    lstr_cell #(
      .NUM_THREADS (NUM_THREADS),
      .CELL_ID     (g),
      .IDW         (IDW)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctl_i         (ctl),
      .rpt_en_i      (rpt_en[g]),
      .rpt_amount_i  (amount),
      .probe_total_i (pr_tot[PREV]),
      .probe_id_i    (pr_id[PREV]),
      .probe_valid_i (pr_val[PREV]),
      .probe_total_o (pr_tot[g]),
      .probe_id_o    (pr_id[g]),
      .probe_valid_o (pr_val[g]),
      .rank_o        (rank[g]),
      .ever_o        (ever[g])
    );
  end

endmodule
